@@ rtl/core/lcd_line_timing_controller_defines.svh @@
// ----------------------------------------------------------------------------
// LCD line timing controller assertion macros
// Shared property forms for the concurrent checks in the timing core.
// ----------------------------------------------------------------------------
`ifndef LCD_LINE_TIMING_CONTROLLER_DEFINES_SVH
`define LCD_LINE_TIMING_CONTROLLER_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define LLTC_ASSERT_SAME(label, clk, rstn, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (cond) |-> (prop)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define LLTC_ASSERT_NEXT(label, clk, rstn, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (cond) |=> (prop)) \
        else $error(msg);

`endif

@@ rtl/core/lltc_pkg.sv @@
// ----------------------------------------------------------------------------
// LCD line timing controller package
// Request kinds, item and result types, and line timing constants.
// ----------------------------------------------------------------------------
package lltc_pkg;

    // Request kinds carried in the input tuser
    typedef enum logic [1:0] {
        REQ_TICK      = 2'd0,
        REQ_CONTROL   = 2'd1,
        REQ_STATUS_EN = 2'd2,
        REQ_COMPARE   = 2'd3
    } req_kind_t;

    // One input request
    typedef struct packed {
        req_kind_t   req_type;
        logic [7:0]  write_value;
        logic [7:0]  cycles;
    } req_item_t;

    // One result, line in the lowest bits when packed
    typedef struct packed {
        logic        stat_irq;
        logic        vblank_irq;
        logic [7:0]  status_byte;
        logic [1:0]  mode;
        logic [7:0]  line;
    } result_t;

    localparam int RESULT_W = $bits(result_t);
    localparam int OUT_DATA_W = ((RESULT_W + 7) / 8) * 8;

    // Display modes
    localparam logic [1:0] MODE_HBLANK   = 2'd0;
    localparam logic [1:0] MODE_VBLANK   = 2'd1;
    localparam logic [1:0] MODE_SEARCH   = 2'd2;
    localparam logic [1:0] MODE_TRANSFER = 2'd3;

    // Line timing
    localparam logic [9:0] LINE_CYCLES    = 10'd456;
    localparam logic [9:0] SEARCH_BOUND   = LINE_CYCLES - 10'd80;
    localparam logic [9:0] TRANSFER_BOUND = SEARCH_BOUND - 10'd172;
    localparam logic [7:0] VBLANK_FIRST   = 8'd144;
    localparam logic [7:0] LINE_LAST      = 8'd154;

    // Status register layout
    localparam int STAT_COMPARE_FLAG = 2;
    localparam int STAT_EN_HBLANK    = 3;
    localparam int STAT_EN_VBLANK    = 4;
    localparam int STAT_EN_SEARCH    = 5;
    localparam int STAT_EN_COMPARE   = 6;
    localparam logic [7:0] STAT_EN_MASK   = 8'h78;
    localparam logic [7:0] STAT_KEEP_MASK = 8'h07;

    // Display enable bit of the control byte
    localparam int CTRL_DISPLAY_ON = 7;

endpackage

@@ rtl/core/lltc_in_stage.sv @@
// ----------------------------------------------------------------------------
// LCD line timing controller input stage
// Registers one request from the input channel until the core takes it.
// ----------------------------------------------------------------------------
module lltc_in_stage (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  lltc_pkg::req_item_t in_item,
    output logic                held_valid,
    output lltc_pkg::req_item_t held_item,
    input  logic                take
);

    logic                valid_reg;
    logic                valid_next;
    lltc_pkg::req_item_t item_reg;

    // Accept when empty or when the held request leaves this cycle
    assign in_ready   = !valid_reg || take;
    assign valid_next = (in_valid && in_ready) ? 1'b1 : (take ? 1'b0 : valid_reg);

    // Hold valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Capture request payload
    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            item_reg <= in_item;
        end
    end

    assign held_valid = valid_reg;
    assign held_item  = item_reg;

endmodule

@@ rtl/core/lltc_timing.sv @@
// ----------------------------------------------------------------------------
// LCD line timing controller core
// Holds the line timing state and computes one result per request.
// ----------------------------------------------------------------------------
`include "lcd_line_timing_controller_defines.svh"

module lltc_timing (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                advance,
    input  lltc_pkg::req_item_t item,
    output lltc_pkg::result_t   result
);

    logic [9:0]  countdown_reg;
    logic [9:0]  countdown_next;
    logic [7:0]  line_reg;
    logic [7:0]  line_next;
    logic [7:0]  status_reg;
    logic [7:0]  status_next;
    logic        display_on_reg;
    logic        display_on_next;
    logic [7:0]  compare_reg;
    logic [7:0]  compare_next;

    logic [1:0]  tick_mode;
    logic        tick_mode_en;
    logic        line_match;
    logic [10:0] count_diff;
    logic        count_left;
    logic        vblank_irq;
    logic        stat_irq;

    // Pick the mode from line and countdown
    always_comb begin
        if (line_reg >= lltc_pkg::VBLANK_FIRST) begin
            tick_mode    = lltc_pkg::MODE_VBLANK;
            tick_mode_en = status_reg[lltc_pkg::STAT_EN_VBLANK];
        end else if (countdown_reg >= lltc_pkg::SEARCH_BOUND) begin
            tick_mode    = lltc_pkg::MODE_SEARCH;
            tick_mode_en = status_reg[lltc_pkg::STAT_EN_SEARCH];
        end else if (countdown_reg >= lltc_pkg::TRANSFER_BOUND) begin
            tick_mode    = lltc_pkg::MODE_TRANSFER;
            tick_mode_en = 1'b0;
        end else begin
            tick_mode    = lltc_pkg::MODE_HBLANK;
            tick_mode_en = status_reg[lltc_pkg::STAT_EN_HBLANK];
        end
    end

    assign line_match = (line_reg == compare_reg);
    assign count_diff = {1'b0, countdown_reg} - {3'b000, item.cycles};
    assign count_left = !count_diff[10] && (count_diff[9:0] != 10'd0);

    // Next state and interrupts for the request in hand
    always_comb begin
        countdown_next  = countdown_reg;
        line_next       = line_reg;
        status_next     = status_reg;
        display_on_next = display_on_reg;
        compare_next    = compare_reg;
        vblank_irq      = 1'b0;
        stat_irq        = 1'b0;
        case (item.req_type)
            lltc_pkg::REQ_TICK: begin
                if (!display_on_reg) begin
                    countdown_next = lltc_pkg::LINE_CYCLES;
                    line_next      = 8'd0;
                    status_next    = {status_reg[7:2], lltc_pkg::MODE_HBLANK};
                end else begin
                    status_next = {status_reg[7:3], line_match, tick_mode};
                    stat_irq    = (tick_mode_en && (tick_mode != status_reg[1:0])) ||
                                  (line_match && status_reg[lltc_pkg::STAT_EN_COMPARE]);
                    if (count_left) begin
                        countdown_next = count_diff[9:0];
                    end else begin
                        countdown_next = lltc_pkg::LINE_CYCLES;
                        if (line_reg < lltc_pkg::VBLANK_FIRST) begin
                            line_next = line_reg + 8'd1;
                        end else if (line_reg < lltc_pkg::LINE_LAST) begin
                            line_next  = line_reg + 8'd1;
                            vblank_irq = 1'b1;
                        end else begin
                            line_next = 8'd0;
                        end
                    end
                end
            end
            lltc_pkg::REQ_CONTROL: begin
                display_on_next = item.write_value[lltc_pkg::CTRL_DISPLAY_ON];
            end
            lltc_pkg::REQ_STATUS_EN: begin
                status_next = (status_reg & lltc_pkg::STAT_KEEP_MASK) |
                              (item.write_value & lltc_pkg::STAT_EN_MASK);
            end
            lltc_pkg::REQ_COMPARE: begin
                compare_next = item.write_value;
            end
            default: begin
                compare_next = compare_reg;
            end
        endcase
    end

    // Advance state when the request moves on
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            countdown_reg  <= lltc_pkg::LINE_CYCLES;
            line_reg       <= 8'd0;
            status_reg     <= 8'd0;
            display_on_reg <= 1'b0;
            compare_reg    <= 8'd0;
        end else if (advance) begin
            countdown_reg  <= countdown_next;
            line_reg       <= line_next;
            status_reg     <= status_next;
            display_on_reg <= display_on_next;
            compare_reg    <= compare_next;
        end
    end

    assign result.line        = line_next;
    assign result.mode        = status_next[1:0];
    assign result.status_byte = status_next;
    assign result.vblank_irq  = vblank_irq;
    assign result.stat_irq    = stat_irq;

    // Register writes raise no interrupt
    `LLTC_ASSERT_SAME(a_write_no_irq, aclk, aresetn,
        advance && (item.req_type != lltc_pkg::REQ_TICK), !vblank_irq && !stat_irq,
        "interrupt raised by a register write")
    // Line never passes the last line
    `LLTC_ASSERT_SAME(a_line_range, aclk, aresetn, 1'b1, line_reg <= lltc_pkg::LINE_LAST,
        "scanline out of range")
    // Vertical blank interrupt lands on a blanking line
    `LLTC_ASSERT_SAME(a_vblank_line, aclk, aresetn, advance && vblank_irq,
        (line_next > lltc_pkg::VBLANK_FIRST) && (line_next <= lltc_pkg::LINE_LAST),
        "vertical blank interrupt outside blanking lines")
    // Tick with display off parks the countdown
    `LLTC_ASSERT_NEXT(a_display_off_park, aclk, aresetn,
        advance && (item.req_type == lltc_pkg::REQ_TICK) && !display_on_reg,
        (countdown_reg == lltc_pkg::LINE_CYCLES) && (line_reg == 8'd0),
        "display off tick did not reset line timing")

endmodule

@@ rtl/core/lltc_out_stage.sv @@
// ----------------------------------------------------------------------------
// LCD line timing controller output stage
// Result register that holds one result until the receiver takes it.
// ----------------------------------------------------------------------------
module lltc_out_stage (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              load,
    output logic              load_ready,
    input  lltc_pkg::result_t load_result,
    output logic              out_valid,
    input  logic              out_ready,
    output lltc_pkg::result_t out_result
);

    logic              valid_reg;
    logic              valid_next;
    lltc_pkg::result_t result_reg;

    // Free when empty or when the held result leaves this cycle
    assign load_ready = !valid_reg || out_ready;
    assign valid_next = load ? 1'b1 : ((valid_reg && out_ready) ? 1'b0 : valid_reg);

    // Hold valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Capture result payload
    always_ff @(posedge aclk) begin
        if (load) begin
            result_reg <= load_result;
        end
    end

    assign out_valid  = valid_reg;
    assign out_result = result_reg;

endmodule

@@ rtl/core/lcd_line_timing_controller.sv @@
// ----------------------------------------------------------------------------
// LCD line timing controller
// Display mode, scanline and status interrupt timing for a handheld LCD.
// ----------------------------------------------------------------------------
// Usage:
//   The input stream carries one request per transfer: a tick of some machine
//   cycles, or a write of the display control, status enable or line compare
//   register. tuser selects the kind, tdata carries the value and cycle count.
//   Every request gives exactly one result on the output stream: the scanline,
//   mode and status byte after the request, plus the vertical blank and status
//   interrupt flags it raised.
//   An accepted request is held in the input register, the timing update
//   logic runs on it, and its result is loaded into the result register as
//   soon as that register is free; the result can then be taken from there.
//   Throughput is one request per cycle while the receiver keeps m_tready
//   high; the countdown subtract and line compare are combinational logic
//   between the two registers.
//   Reset (aresetn low, synchronous) empties both registers and returns the
//   timing state to display off, line 0, countdown 456, status 0, compare 0.
//   When the receiver holds m_tready low the result waits in the output
//   register, one further request waits in the input register, and s_tready
//   then drops until the result is taken; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module lcd_line_timing_controller (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [15:0]                     s_tdata,   // write_value[7:0], cycles[15:8]
    input  logic [1:0]                      s_tuser,   // req_type[1:0]
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // line[7:0], mode[9:8], status_byte[17:10], vblank_irq[18], stat_irq[19], zeros above
    output logic [lltc_pkg::OUT_DATA_W-1:0] m_tdata
);

    lltc_pkg::req_item_t in_item;
    lltc_pkg::req_item_t held_item;
    logic                held_valid;
    logic                load_ready;
    logic                advance;
    lltc_pkg::result_t   core_result;
    lltc_pkg::result_t   out_result;

    // Unpack the input request
    assign in_item.req_type    = lltc_pkg::req_kind_t'(s_tuser);
    assign in_item.write_value = s_tdata[7:0];
    assign in_item.cycles      = s_tdata[15:8];

    // Move a request through the core when the result register is free
    assign advance = held_valid && load_ready;

    lltc_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_item    (in_item),
        .held_valid (held_valid),
        .held_item  (held_item),
        .take       (advance)
    );

    lltc_timing u_timing (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .item    (held_item),
        .result  (core_result)
    );

    lltc_out_stage u_out_stage (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .load        (advance),
        .load_ready  (load_ready),
        .load_result (core_result),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_result  (out_result)
    );

    // Pack the result, zero fill to whole bytes
    assign m_tdata = {{(lltc_pkg::OUT_DATA_W - lltc_pkg::RESULT_W){1'b0}}, out_result};

endmodule

@@ test/lcd_line_timing_controller_tb.sv @@
// ----------------------------------------------------------------------------
// LCD line timing controller testbench
// Drives tick and register write requests into the stream input, predicts
// the scanline, mode, status byte and interrupt flags of every request, and
// compares each result taken from the output stream with the oldest
// prediction. A short directed table comes first, then random requests that
// mostly keep the display on, so that whole frames with vertical blank and
// line wrap are run, across phases of sender idling, receiver stalling and
// one long receiver hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module lcd_line_timing_controller_tb;

    import lltc_pkg::*;

    // Watchdog limit in cycles with no transfer on either side; the longest
    // correct quiet stretch is the receiver hold-off below.
    localparam int IDLE_LIMIT       = 2000;
    localparam int HOLD_CYCLES      = 200;
    localparam int RANDOM_PER_PHASE = 300;
    localparam int PHASE_COUNT      = 5;
    localparam int DRAIN_CYCLES     = 10;

    typedef struct {
        req_kind_t  kind;
        logic [7:0] value;
        logic [7:0] cycles;
        bit         typed;
        result_t    want;
    } stim_row_t;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic [15:0]           s_tdata  = '0;
    logic [1:0]            s_tuser  = '0;
    logic                  m_tready = 1'b0;
    wire                   s_tready;
    wire                   m_tvalid;
    wire [OUT_DATA_W-1:0]  m_tdata;

    // Typed expectation that rides along with the request on the bus
    bit      req_typed = 1'b0;
    result_t req_want  = '0;

    // Predictor state
    logic [9:0] pred_countdown = LINE_CYCLES;
    logic [7:0] pred_line      = '0;
    logic [7:0] pred_status    = '0;
    logic       pred_lcd_on    = 1'b0;
    logic [7:0] pred_compare   = '0;

    result_t   expected_results[$];
    stim_row_t directed_rows[$];
    int        err_count  = 0;
    int        idle_count = 0;
    int        sender_pct = 0;
    int        recv_pct   = 0;
    bit        hold_now   = 1'b0;

    lcd_line_timing_controller i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Print one mismatch line and count it
    task automatic report_error(input string msg);
        $display("%0t: %s", $realtime, msg);
        err_count++;
    endtask

    function automatic result_t result_of(input logic [7:0] line, input logic [7:0] status);
        result_t r;
        r             = '0;
        r.line        = line;
        r.mode        = status[1:0];
        r.status_byte = status;
        return r;
    endfunction

    // Advance the line timing by one request and return its result
    function automatic result_t next_line_timing(input req_item_t req);
        result_t    res;
        logic [1:0] old_mode;
        logic [1:0] new_mode;
        logic       en_hit;
        int         remain;
        res = '0;
        case (req.req_type)
            REQ_TICK: begin
                if (!pred_lcd_on) begin
                    pred_countdown   = LINE_CYCLES;
                    pred_line        = '0;
                    pred_status[1:0] = MODE_HBLANK;
                end else begin
                    // Pick the mode from line and countdown
                    old_mode = pred_status[1:0];
                    if (pred_line >= VBLANK_FIRST) begin
                        new_mode = MODE_VBLANK;
                        en_hit   = pred_status[STAT_EN_VBLANK];
                    end else if (pred_countdown >= SEARCH_BOUND) begin
                        new_mode = MODE_SEARCH;
                        en_hit   = pred_status[STAT_EN_SEARCH];
                    end else if (pred_countdown >= TRANSFER_BOUND) begin
                        new_mode = MODE_TRANSFER;
                        en_hit   = 1'b0;
                    end else begin
                        new_mode = MODE_HBLANK;
                        en_hit   = pred_status[STAT_EN_HBLANK];
                    end
                    pred_status[1:0] = new_mode;
                    if (en_hit && new_mode != old_mode)
                        res.stat_irq = 1'b1;

                    // Line compare fires on every matching tick
                    if (pred_line == pred_compare) begin
                        pred_status[STAT_COMPARE_FLAG] = 1'b1;
                        if (pred_status[STAT_EN_COMPARE])
                            res.stat_irq = 1'b1;
                    end else begin
                        pred_status[STAT_COMPARE_FLAG] = 1'b0;
                    end

                    // Count down; an overrun reloads and drops the excess
                    remain = int'(pred_countdown) - int'(req.cycles);
                    if (remain > 0) begin
                        pred_countdown = remain[9:0];
                    end else begin
                        pred_countdown = LINE_CYCLES;
                        if (pred_line < VBLANK_FIRST) begin
                            pred_line++;
                        end else if (pred_line < LINE_LAST) begin
                            res.vblank_irq = 1'b1;
                            pred_line++;
                        end else begin
                            pred_line = '0;
                        end
                    end
                end
            end
            REQ_CONTROL: begin
                pred_lcd_on = req.write_value[CTRL_DISPLAY_ON];
            end
            REQ_STATUS_EN: begin
                pred_status = (pred_status & STAT_KEEP_MASK) | (req.write_value & STAT_EN_MASK);
            end
            default: begin
                pred_compare = req.write_value;
            end
        endcase
        res.line        = pred_line;
        res.mode        = pred_status[1:0];
        res.status_byte = pred_status;
        return res;
    endfunction

    // Check results and predict every accepted request
    always @(posedge aclk) begin : scoreboard
        result_t   got;
        result_t   want;
        result_t   pred;
        req_item_t item;
        if (!aresetn) begin
            pred_countdown = LINE_CYCLES;
            pred_line      = '0;
            pred_status    = '0;
            pred_lcd_on    = 1'b0;
            pred_compare   = '0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = m_tdata[RESULT_W-1:0];
                if (expected_results.size() == 0) begin
                    report_error($sformatf("result with no request pending: %h", got));
                end else begin
                    want = expected_results.pop_front();
                    if (got.line !== want.line)
                        report_error($sformatf("line got %0d want %0d", got.line, want.line));
                    if (got.mode !== want.mode)
                        report_error($sformatf("mode got %0d want %0d", got.mode, want.mode));
                    if (got.status_byte !== want.status_byte)
                        report_error($sformatf("status got %h want %h",
                                               got.status_byte, want.status_byte));
                    if (got.vblank_irq !== want.vblank_irq)
                        report_error($sformatf("vblank_irq got %b want %b",
                                               got.vblank_irq, want.vblank_irq));
                    if (got.stat_irq !== want.stat_irq)
                        report_error($sformatf("stat_irq got %b want %b",
                                               got.stat_irq, want.stat_irq));
                end
            end
            if (s_tvalid && s_tready) begin
                item.req_type    = req_kind_t'(s_tuser);
                item.write_value = s_tdata[7:0];
                item.cycles      = s_tdata[15:8];
                pred             = next_line_timing(item);
                expected_results.push_back(req_typed ? req_want : pred);
            end
        end
    end

    // Watchdog on cycles with no transfer at all
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_count <= 0;
        end else if (idle_count + 1 >= IDLE_LIMIT) begin
            $display("lcd_line_timing_controller_tb: done, errors");
            $finish;
        end else begin
            idle_count <= idle_count + 1;
        end
    end

    // Receiver: random stalls, or one long hold-off when asked
    initial begin
        forever begin
            @(negedge aclk);
            if (hold_now) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_now = 1'b0;
            end else if (aresetn) begin
                m_tready <= ($urandom_range(99) >= recv_pct);
            end
        end
    end

    // Offer one request, starting and ending at a falling edge
    task automatic send_req(input req_kind_t kind, input logic [7:0] value,
                            input logic [7:0] cyc, input bit typed, input result_t want);
        while ($urandom_range(99) < sender_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid  <= 1'b1;
        s_tuser   <= kind;
        s_tdata   <= {cyc, value};
        req_typed <= typed;
        req_want  <= want;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    initial begin : stimulus
        int         pick;
        req_kind_t  kind;
        logic [7:0] value;
        logic [7:0] cyc;
        stim_row_t  row;

        // Directed table: typed rows where the result is plain from the spec
        directed_rows.push_back('{REQ_TICK,      8'h00, 8'h00, 1'b1, result_of(8'd0, 8'h00)});
        directed_rows.push_back('{REQ_TICK,      8'hFF, 8'hFF, 1'b1, result_of(8'd0, 8'h00)});
        directed_rows.push_back('{REQ_STATUS_EN, 8'hFF, 8'h00, 1'b1, result_of(8'd0, 8'h78)});
        directed_rows.push_back('{REQ_STATUS_EN, 8'h00, 8'hFF, 1'b1, result_of(8'd0, 8'h00)});
        directed_rows.push_back('{REQ_COMPARE,   8'hFF, 8'h00, 1'b1, result_of(8'd0, 8'h00)});
        directed_rows.push_back('{REQ_COMPARE,   8'h00, 8'h00, 1'b1, result_of(8'd0, 8'h00)});
        directed_rows.push_back('{REQ_STATUS_EN, 8'h78, 8'h00, 1'b1, result_of(8'd0, 8'h78)});
        directed_rows.push_back('{REQ_CONTROL,   8'h7F, 8'h00, 1'b1, result_of(8'd0, 8'h78)});
        directed_rows.push_back('{REQ_CONTROL,   8'h80, 8'h00, 1'b1, result_of(8'd0, 8'h78)});
        // Enter search with compare match, then walk the mode boundaries
        directed_rows.push_back('{REQ_TICK,      8'h00, 8'd0,   1'b0, '0});
        directed_rows.push_back('{REQ_TICK,      8'h00, 8'd80,  1'b0, '0});
        directed_rows.push_back('{REQ_TICK,      8'h00, 8'd1,   1'b0, '0});
        directed_rows.push_back('{REQ_TICK,      8'h00, 8'd172, 1'b0, '0});
        directed_rows.push_back('{REQ_TICK,      8'h00, 8'd0,   1'b0, '0});
        // Overrun past zero, then land exactly on zero
        directed_rows.push_back('{REQ_TICK,      8'h00, 8'd255, 1'b0, '0});
        directed_rows.push_back('{REQ_TICK,      8'h00, 8'd255, 1'b0, '0});
        directed_rows.push_back('{REQ_TICK,      8'h00, 8'd201, 1'b0, '0});
        directed_rows.push_back('{REQ_COMPARE,   8'd2,  8'd0,   1'b0, '0});
        directed_rows.push_back('{REQ_TICK,      8'h00, 8'd1,   1'b0, '0});
        // Display off mid-line keeps the compare flag
        directed_rows.push_back('{REQ_CONTROL,   8'h00, 8'd0,   1'b0, '0});
        directed_rows.push_back('{REQ_TICK,      8'h00, 8'd100, 1'b0, '0});
        directed_rows.push_back('{REQ_STATUS_EN, 8'h87, 8'd0,   1'b0, '0});
        directed_rows.push_back('{REQ_CONTROL,   8'hFF, 8'd0,   1'b0, '0});
        directed_rows.push_back('{REQ_TICK,      8'hFF, 8'd255, 1'b0, '0});

        // Hold reset, then release it at a falling edge
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            send_req(row.kind, row.value, row.cycles, row.typed, row.want);
        end

        // Random phases: none, sender idle, receiver stall, both, hold-off
        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            case (phase)
                0: begin sender_pct = 0;  recv_pct = 0;  end
                1: begin sender_pct = 56; recv_pct = 0;  end
                2: begin sender_pct = 0;  recv_pct = 56; end
                3: begin sender_pct = 10; recv_pct = 10; end
                default: begin
                    sender_pct = 0;
                    recv_pct   = 0;
                    hold_now   = 1'b1;
                end
            endcase
            for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
                pick  = $urandom_range(999);
                value = 8'($urandom);
                cyc   = 8'($urandom);
                if (!pred_lcd_on) begin
                    // Mostly turn the display back on
                    if (pick < 800) begin
                        kind  = REQ_CONTROL;
                        value = value | 8'h80;
                    end else begin
                        kind = req_kind_t'($urandom_range(3));
                    end
                end else if (pick < 900) begin
                    kind = REQ_TICK;
                    if ($urandom_range(9) < 7)
                        cyc = 8'($urandom_range(128, 255));
                    else if ($urandom_range(2) == 0)
                        cyc = 8'($urandom_range(8));
                end else if (pick < 950) begin
                    kind = REQ_STATUS_EN;
                end else if (pick < 980) begin
                    kind = REQ_COMPARE;
                    if ($urandom_range(1) == 0)
                        value = 8'($urandom_range(140, 154));
                end else if (pick < 983) begin
                    kind  = REQ_CONTROL;
                    value = value & 8'h7F;
                end else begin
                    kind  = REQ_CONTROL;
                    value = value | 8'h80;
                end
                send_req(kind, value, cyc, 1'b0, '0);
            end
        end

        // Drop valid and drain
        s_tvalid <= 1'b0;
        wait (expected_results.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (err_count == 0) begin
            $display("lcd_line_timing_controller_tb: done, clean");
        end else begin
            $display("lcd_line_timing_controller_tb: done, errors");
        end
        $finish;
    end

endmodule
